// ----- design/afe_pkg.sv -----
// Package for the escaped API frame encoder.
// Holds the job descriptor passed from the front part to the back part, plus the frame constants.
// No dependencies.
`default_nettype none

package afe_pkg;

	localparam logic ACT_BEGIN   = 1'b0;
	localparam logic ACT_PAYLOAD = 1'b1;

	localparam logic [7:0] START_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE   = 8'h7D;
	localparam logic [7:0] XON_BYTE   = 8'h11;
	localparam logic [7:0] XOFF_BYTE  = 8'h13;
	localparam logic [7:0] ESC_XOR    = 8'h20;
	localparam logic [7:0] CSUM_BASE  = 8'hFF;

	localparam int MAX_SYMS = 4;

	// One accepted item, broken into up to four unescaped symbols.
	typedef struct packed {
		logic [MAX_SYMS-1:0][7:0] sym;      // symbol bytes, index 0 first
		logic [MAX_SYMS-1:0]      esc_en;   // symbol may be escaped
		logic [1:0]               last_idx; // index of the final symbol
		logic                     has_csum; // final symbol is the checksum
		logic                     bad;      // payload outside an open frame
	} job_t;

	function automatic logic is_special(input logic [7:0] b);
		return (b == START_BYTE) || (b == ESC_BYTE) || (b == XON_BYTE) || (b == XOFF_BYTE);
	endfunction

endpackage

`default_nettype wire

// ----- design/afe_front.sv -----
// Front part: accepts input items, keeps the frame state and builds one job per item.
// Depends on afe_pkg.
`default_nettype none

module afe_front
	import afe_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic        action,
	input  wire logic [15:0] frame_length,
	input  wire logic [7:0]  payload_byte,
	output job_t             job
);

	logic [15:0] bytes_remaining_q;
	logic [7:0]  running_sum_q;
	logic        frame_open_q;

	logic [15:0] rem_n;
	logic [7:0]  sum_n;
	logic        open_n;
	logic [15:0] rem_dec;
	logic [7:0]  sum_add;

	assign rem_dec = bytes_remaining_q - 16'd1;
	assign sum_add = running_sum_q + payload_byte;

	always_comb begin
		job    = '0;
		rem_n  = bytes_remaining_q;
		sum_n  = running_sum_q;
		open_n = frame_open_q;
		if (action == ACT_BEGIN) begin
			job.sym[0]    = START_BYTE;
			job.sym[1]    = frame_length[15:8];
			job.sym[2]    = frame_length[7:0];
			job.esc_en    = 4'b1110;
			job.last_idx  = 2'd2;
			rem_n         = frame_length;
			sum_n         = '0;
			open_n        = 1'b1;
			if (frame_length == 16'd0) begin
				// Empty frame: close at once with the checksum of nothing.
				job.sym[3]   = CSUM_BASE;
				job.last_idx = 2'd3;
				job.has_csum = 1'b1;
				open_n       = 1'b0;
			end
		end else if (!frame_open_q || bytes_remaining_q == 16'd0) begin
			// Drop the byte and flag it; state holds.
			job.bad = 1'b1;
		end else begin
			job.sym[0]    = payload_byte;
			job.esc_en    = 4'b0011;
			rem_n         = rem_dec;
			sum_n         = sum_add;
			if (rem_dec == 16'd0) begin
				job.sym[1]   = CSUM_BASE - sum_add;
				job.last_idx = 2'd1;
				job.has_csum = 1'b1;
				sum_n        = '0;
				open_n       = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_remaining_q <= '0;
			running_sum_q     <= '0;
			frame_open_q      <= 1'b0;
		end else if (accept) begin
			bytes_remaining_q <= rem_n;
			running_sum_q     <= sum_n;
			frame_open_q      <= open_n;
		end
	end

endmodule

`default_nettype wire

// ----- design/afe_job_fifo.sv -----
// Short job queue between the front and back parts.
// Depends on afe_pkg.
`default_nettype none

module afe_job_fifo
	import afe_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	input  wire logic pop,
	output job_t      head_job,
	output logic      full,
	output logic      not_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t          slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign head_job  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/afe_back.sv -----
// Back part: walks the head job symbol by symbol, inserts escapes and drives the output register.
// Depends on afe_pkg.
`default_nettype none

module afe_back
	import afe_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       job_ready,
	input  wire job_t       job,
	output logic            job_pop,
	input  wire logic       byte_stall,
	output logic            byte_valid,
	output logic [7:0]      out_byte,
	output logic            frame_end,
	output logic            run_last,
	output logic            status
);

	logic [1:0] pos_q;
	logic       esc_half_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       end_q;
	logic       last_q;
	logic       status_q;

	logic       advance;
	logic [7:0] cur_sym;
	logic       need_esc;
	logic       final_byte;
	logic       last_sym;
	logic [7:0] emit_byte;

	assign cur_sym    = job.sym[pos_q];
	assign need_esc   = job.esc_en[pos_q] && is_special(cur_sym);
	assign final_byte = !(need_esc && !esc_half_q);
	assign last_sym   = (pos_q == job.last_idx);
	assign advance    = job_ready && (!valid_q || !byte_stall);
	assign job_pop    = advance && final_byte && last_sym;
	assign emit_byte  = !final_byte ? ESC_BYTE : (esc_half_q ? (cur_sym ^ ESC_XOR) : cur_sym);

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q   <= emit_byte;
			end_q    <= final_byte && last_sym && job.has_csum;
			last_q   <= final_byte && last_sym;
			status_q <= job.bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			pos_q      <= '0;
			esc_half_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_q <= 1'b1;
				if (!final_byte) begin
					esc_half_q <= 1'b1;
				end else begin
					esc_half_q <= 1'b0;
					pos_q      <= last_sym ? 2'd0 : pos_q + 2'd1;
				end
			end else if (!byte_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign byte_valid = valid_q;
	assign out_byte   = byte_q;
	assign frame_end  = end_q;
	assign run_last   = last_q;
	assign status     = status_q;

endmodule

`default_nettype wire

// ----- design/api_frame_escape_encoder.sv -----
// Escaped API frame encoder, top level.
// Instantiates afe_front, afe_job_fifo and afe_back; depends on afe_pkg.
//
// Input channel (item_valid / item_stall): one item is either a begin with frame_length
// (action 0) or one payload byte (action 1). Output channel (byte_valid / byte_stall):
// one wire byte per transfer, with frame_end on the final checksum byte, run_last on the
// last byte caused by an input item, and status set on the single flagged result of
// a payload byte that arrived outside an open frame.
// An item accepted with the queue empty is written into the job queue, and its first
// byte then goes through the back part's output register onto out_byte.
// Throughput: while byte_stall is low the back part emits one wire byte per cycle; an
// item produces 1 to 2 bytes for a payload byte (up to 4 when it closes the frame with
// an escaped checksum) and 3 to 5 for a begin. The job queue (QUEUE_DEPTH
// entries) lets the front keep accepting while the back is busy; item_stall rises
// only when the queue is full.
// Reset clears the frame state, the queue and the output valid; no frame is open.
// When byte_stall is high the output byte holds, the back part stops and the queue
// fills, after which item_stall backs up to the sender.
`default_nettype none

module api_frame_escape_encoder
	import afe_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic        action,
	input  wire logic [15:0] frame_length,
	input  wire logic [7:0]  payload_byte,
	output logic             byte_valid,
	input  wire logic        byte_stall,
	output logic [7:0]       out_byte,
	output logic             frame_end,
	output logic             run_last,
	output logic             status
);

	job_t new_job;
	job_t head_job;
	logic q_full;
	logic q_not_empty;
	logic q_pop;
	logic item_accept;

	// Take an item whenever the queue has room.
	assign item_stall  = q_full;
	assign item_accept = item_valid && !q_full;

	afe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (item_accept),
		.action       (action),
		.frame_length (frame_length),
		.payload_byte (payload_byte),
		.job          (new_job)
	);

	afe_job_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (item_accept),
		.push_job  (new_job),
		.pop       (q_pop),
		.head_job  (head_job),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	afe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_ready  (q_not_empty),
		.job        (head_job),
		.job_pop    (q_pop),
		.byte_stall (byte_stall),
		.byte_valid (byte_valid),
		.out_byte   (out_byte),
		.frame_end  (frame_end),
		.run_last   (run_last),
		.status     (status)
	);

`ifndef SYNTHESIS
	// The checksum byte always ends the item that caused it.
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && frame_end |-> run_last)
		else $error("frame_end without run_last");

	// A flagged result is a lone zero byte outside any frame.
	a_bad_shape: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && status |-> out_byte == 8'h00 && run_last && !frame_end)
		else $error("malformed flagged result");

	// An accepted item is checked to be followed by byte_valid at the output.
	a_item_flows: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |-> ##2 byte_valid)
		else $error("accepted item did not reach the output");
`endif

endmodule

`default_nettype wire
